[hdl/mass_spring_damper_bdf_step_core_assert.svh]
// Assertion macros for the mass-spring-damper step core checker
`ifndef MASS_SPRING_DAMPER_BDF_STEP_CORE_ASSERT_SVH
`define MASS_SPRING_DAMPER_BDF_STEP_CORE_ASSERT_SVH

// same-cycle implication
`define MSD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MSD_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/msd_pkg.sv]
// Shared constants, weight tables and unit status type for the step core
`timescale 1ns / 1ps
package msd_pkg;

   localparam int DATA_WIDTH_DEF = 48;
   localparam int FRAC_BITS_DEF  = 24;
   localparam int DIV_WIDTH      = 10;
   localparam int WGT_WIDTH      = 7;

   localparam logic [2:0] CSR_STIFFNESS    = 3'd0;
   localparam logic [2:0] CSR_DAMPING      = 3'd1;
   localparam logic [2:0] CSR_INVERSE_MASS = 3'd2;
   localparam logic [2:0] CSR_GRAVITY      = 3'd3;
   localparam logic [2:0] CSR_FREE_LENGTH  = 3'd4;
   localparam logic [2:0] CSR_TIME_STEP    = 3'd5;
   localparam logic [2:0] CSR_STEP_HEIGHT  = 3'd6;
   localparam logic [2:0] CSR_START_TIME   = 3'd7;

   localparam logic [DIV_WIDTH-1:0] DIV_RAMP = 10'd50;
   localparam logic [DIV_WIDTH-1:0] DIV_HOLD = 10'd1000;

   typedef struct packed {
      logic done;
      logic sat;
   } msd_stat_type;

   // slot 0 weights the h term, slots 1..4 the history, newest first
   function automatic logic signed [WGT_WIDTH-1:0] term_weight(input logic [1:0] ord,
                                                              input logic [2:0] slot);
      logic signed [WGT_WIDTH-1:0] k;
      k = '0;
      case (ord)
         2'd0: begin
            case (slot)
               3'd0:    k = 7'sd1;
               3'd1:    k = 7'sd1;
               default: k = 7'sd0;
            endcase
         end
         2'd1: begin
            case (slot)
               3'd0:    k = 7'sd2;
               3'd1:    k = 7'sd4;
               3'd2:    k = -7'sd1;
               default: k = 7'sd0;
            endcase
         end
         2'd2: begin
            case (slot)
               3'd0:    k = 7'sd6;
               3'd1:    k = 7'sd18;
               3'd2:    k = -7'sd9;
               3'd3:    k = 7'sd2;
               default: k = 7'sd0;
            endcase
         end
         default: begin
            case (slot)
               3'd0:    k = 7'sd12;
               3'd1:    k = 7'sd48;
               3'd2:    k = -7'sd36;
               3'd3:    k = 7'sd16;
               3'd4:    k = -7'sd3;
               default: k = 7'sd0;
            endcase
         end
      endcase
      return k;
   endfunction

   function automatic logic [DIV_WIDTH-1:0] order_divisor(input logic [1:0] ord);
      logic [DIV_WIDTH-1:0] d;
      case (ord)
         2'd0:    d = 10'd1;
         2'd1:    d = 10'd3;
         2'd2:    d = 10'd11;
         default: d = 10'd25;
      endcase
      return d;
   endfunction

endpackage

[hdl/msd_ser_mul.sv]
// Bit-serial fixed-point multiplier with round-to-nearest and saturation
`timescale 1ns / 1ps
module msd_ser_mul #(
   parameter int DATA_WIDTH = msd_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = msd_pkg::FRAC_BITS_DEF
)(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [DATA_WIDTH-1:0] op_a,
   input  logic signed [DATA_WIDTH-1:0] op_b,
   output logic signed [DATA_WIDTH-1:0] product,
   output msd_pkg::msd_stat_type        stat
);
   import msd_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int CW = $clog2(W + 1);
   localparam int RW = 2 * W + 1;
   localparam logic [RW-1:0] HALF    = RW'(1) << (FRAC_BITS - 1);
   localparam logic [RW-1:0] LIM_NEG = RW'(1) << (W - 1);
   localparam logic [RW-1:0] LIM_POS = LIM_NEG - RW'(1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [W-1:0]        am_ff, am_in;
   logic [W-1:0]        hi_ff, hi_in;
   logic [W-1:0]        bsh_ff, bsh_in;
   logic                neg_ff, neg_in;
   logic signed [W-1:0] res_ff, res_in;
   logic                sat_ff, sat_in;

   logic [W:0]    psum;
   logic [RW-1:0] rnd;
   logic [RW-1:0] shifted;
   logic [RW-1:0] lim;
   logic          ovf;
   logic [W-1:0]  mag;

   always_comb begin
      psum    = {1'b0, hi_ff} + (bsh_ff[0] ? {1'b0, am_ff} : '0);
      rnd     = {1'b0, hi_ff, bsh_ff} + HALF;
      shifted = rnd >> FRAC_BITS;
      lim     = neg_ff ? LIM_NEG : LIM_POS;
      ovf     = shifted > lim;
      mag     = ovf ? lim[W-1:0] : shifted[W-1:0];

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      am_in   = am_ff;
      hi_in   = hi_ff;
      bsh_in  = bsh_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      sat_in  = sat_ff;

      if (start) begin
         am_in   = op_a[W-1] ? W'(-op_a) : W'(op_a);
         bsh_in  = op_b[W-1] ? W'(-op_b) : W'(op_b);
         neg_in  = op_a[W-1] ^ op_b[W-1];
         hi_in   = '0;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            hi_in  = psum[W:1];
            bsh_in = {psum[0], bsh_ff[W-1:1]};
            cnt_in = cnt_ff - CW'(1);
         end else begin
            res_in  = neg_ff ? -$signed(mag) : $signed(mag);
            sat_in  = ovf;
            done_in = 1'b1;
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      am_ff  <= am_in;
      hi_ff  <= hi_in;
      bsh_ff <= bsh_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
      sat_ff <= sat_in;
   end

   assign product   = res_ff;
   assign stat.done = done_ff;
   assign stat.sat  = sat_ff;

endmodule

[hdl/msd_ser_div.sv]
// Bit-serial restoring divider by a small constant, rounding ties away from zero
`timescale 1ns / 1ps
module msd_ser_div #(
   parameter int NUM_WIDTH = msd_pkg::DATA_WIDTH_DEF + 8
)(
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [NUM_WIDTH-1:0]       dividend,
   input  logic [msd_pkg::DIV_WIDTH-1:0]     divisor,
   output logic signed [NUM_WIDTH-1:0]       quotient,
   output msd_pkg::msd_stat_type             stat
);
   import msd_pkg::*;

   localparam int N  = NUM_WIDTH;
   localparam int CW = $clog2(N + 1);
   localparam int DW = DIV_WIDTH;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [N-1:0]        nsh_ff, nsh_in;
   logic [DW-1:0]       rem_ff, rem_in;
   logic [DW-1:0]       dv_ff, dv_in;
   logic                neg_ff, neg_in;
   logic signed [N-1:0] quot_ff, quot_in;

   logic [DW:0]  trial;
   logic [DW:0]  diff;
   logic         ge;
   logic [N-1:0] mag;

   always_comb begin
      trial = {rem_ff, nsh_ff[N-1]};
      diff  = trial - {1'b0, dv_ff};
      ge    = trial >= {1'b0, dv_ff};
      mag   = dividend[N-1] ? N'(-dividend) : N'(dividend);

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      nsh_in  = nsh_ff;
      rem_in  = rem_ff;
      dv_in   = dv_ff;
      neg_in  = neg_ff;
      quot_in = quot_ff;

      if (start) begin
         // bias by half the divisor so truncation rounds to nearest
         nsh_in  = mag + N'(divisor >> 1);
         rem_in  = '0;
         dv_in   = divisor;
         neg_in  = dividend[N-1];
         cnt_in  = CW'(N);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
            nsh_in = {nsh_ff[N-2:0], ge};
            cnt_in = cnt_ff - CW'(1);
         end else begin
            quot_in = neg_ff ? -$signed(nsh_ff) : $signed(nsh_ff);
            done_in = 1'b1;
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      nsh_ff  <= nsh_in;
      rem_ff  <= rem_in;
      dv_ff   <= dv_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign quotient  = quot_ff;
   assign stat.done = done_ff;
   assign stat.sat  = 1'b0;

endmodule

[hdl/mass_spring_damper_bdf_step_core.sv]
// Top level: mass-spring-damper integrator, one BDF step per request word
`timescale 1ns / 1ps
// Usage
//   req_*  : one word per integration step; req_restart=1 returns the position
//            and velocity history, step count and elapsed time to their reset
//            values before the step. req_stall is high while a step is in work.
//   rsp_*  : one result word per step: position, velocity, acceleration, force,
//            time after the step, order used (1..4) and a saturation flag.
//            rsp_stall holds the word; the block may take the next request
//            meanwhile and parks its result until the output register frees.
//   csr_*  : register writes, always ready; write only while no step is open.
// Sequencing
//   One step at a time. Cost is set by the bit-serial multiplier (6 products
//   per step, 5 in the hold phase of the ground) and the bit-serial constant
//   divider (4 or 3 quotients per step), plus the two weighted history sums
//   and the time and done states. The result word is posted as the sequencer
//   returns to idle, and the next request word can be taken from then on.
// Reset
//   Synchronous, active high: registers and state take their reset values.
module mass_spring_damper_bdf_step_core #(
   parameter int DATA_WIDTH = msd_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = msd_pkg::FRAC_BITS_DEF
)(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_restart,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_new_position,
   output logic signed [DATA_WIDTH-1:0] rsp_new_velocity,
   output logic signed [DATA_WIDTH-1:0] rsp_acceleration,
   output logic signed [DATA_WIDTH-1:0] rsp_net_force,
   output logic signed [DATA_WIDTH-1:0] rsp_sim_time,
   output logic [2:0]                   rsp_order_used,
   output logic                         rsp_saturated,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [2:0]                   csr_index,
   input  logic [DATA_WIDTH-1:0]        csr_data
);
   import msd_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int XW = W + 9;   // room for exact sums before clipping
   localparam int SW = W + 8;   // weighted-sum and dividend width

   localparam logic signed [W-1:0]  VMAX_W = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0]  VMIN_W = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [XW-1:0] VMAX_X = XW'(VMAX_W);
   localparam logic signed [XW-1:0] VMIN_X = XW'(VMIN_W);
   localparam logic signed [W-1:0]  HALF_W = W'(64'd1 << (FRAC_BITS - 1));
   localparam logic [W-2:0]         INVM_RST = (W-1)'(64'd1 << FRAC_BITS);
   localparam logic [W-2:0]         DT_RST = (W-1)'((64'd1 << FRAC_BITS) / 1000);
   // 0.05 s, end of the ground ramp
   localparam logic signed [W-1:0]  THR_W = W'(((64'd1 << FRAC_BITS) + 64'd10) / 64'd20);

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_TIME  = 4'd1;
   localparam logic [3:0] S_GMUL  = 4'd2;
   localparam logic [3:0] S_XGDIV = 4'd3;
   localparam logic [3:0] S_VGDIV = 4'd4;
   localparam logic [3:0] S_FK    = 4'd5;
   localparam logic [3:0] S_FD    = 4'd6;
   localparam logic [3:0] S_ACC   = 4'd7;
   localparam logic [3:0] S_HV    = 4'd8;
   localparam logic [3:0] S_SUMV  = 4'd9;
   localparam logic [3:0] S_DIVV  = 4'd10;
   localparam logic [3:0] S_HX    = 4'd11;
   localparam logic [3:0] S_SUMX  = 4'd12;
   localparam logic [3:0] S_DIVX  = 4'd13;
   localparam logic [3:0] S_DONE  = 4'd14;

   function automatic logic ovf_x(input logic signed [XW-1:0] v);
      return (v > VMAX_X) || (v < VMIN_X);
   endfunction

   function automatic logic signed [W-1:0] clip_x(input logic signed [XW-1:0] v);
      logic signed [W-1:0] r;
      if (v > VMAX_X) r = VMAX_W;
      else if (v < VMIN_X) r = VMIN_W;
      else r = v[W-1:0];
      return r;
   endfunction

   // configuration registers
   logic [W-2:0]        stiff_ff, stiff_in;
   logic [W-2:0]        damp_ff, damp_in;
   logic [W-2:0]        invm_ff, invm_in;
   logic signed [W-1:0] grav_ff, grav_in;
   logic signed [W-1:0] flen_ff, flen_in;
   logic [W-2:0]        dt_ff, dt_in;
   logic signed [W-1:0] height_ff, height_in;
   logic signed [W-1:0] t0_ff, t0_in;

   // integrator state, entry 0 newest
   logic signed [W-1:0] pos_ff [0:3];
   logic signed [W-1:0] pos_in [0:3];
   logic signed [W-1:0] vel_ff [0:3];
   logic signed [W-1:0] vel_in [0:3];
   logic [1:0]          steps_ff, steps_in;
   logic signed [W-1:0] elapsed_ff, elapsed_in;

   // sequencer control
   logic [3:0] state_ff, state_in;
   logic       run_ff, run_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // working values
   logic [1:0]           ord_ff, ord_in;
   logic                 ramp_ff, ramp_in;
   logic                 sat_ff, sat_in;
   logic signed [W-1:0]  t_ff, t_in;
   logic signed [W-1:0]  tmp_ff, tmp_in;
   logic signed [W-1:0]  xg_ff, xg_in;
   logic signed [W-1:0]  vg_ff, vg_in;
   logic signed [W-1:0]  facc_ff, facc_in;
   logic signed [W-1:0]  force_ff, force_in;
   logic signed [W-1:0]  acc_ff, acc_in;
   logic signed [W-1:0]  h_ff, h_in;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic signed [W-1:0]  vnew_ff, vnew_in;
   logic signed [W-1:0]  xnew_ff, xnew_in;

   // result word
   logic signed [W-1:0] o_pos_ff, o_pos_in;
   logic signed [W-1:0] o_vel_ff, o_vel_in;
   logic signed [W-1:0] o_acc_ff, o_acc_in;
   logic signed [W-1:0] o_force_ff, o_force_in;
   logic signed [W-1:0] o_time_ff, o_time_in;
   logic [2:0]          o_ord_ff, o_ord_in;
   logic                o_sat_ff, o_sat_in;

   // shared units
   logic                 mul_start;
   logic signed [W-1:0]  mul_a, mul_b, mul_res;
   msd_stat_type         mul_stat;
   logic                 div_start;
   logic signed [SW-1:0] div_num, div_q;
   logic [DIV_WIDTH-1:0] div_den;
   msd_stat_type         div_stat;

   // combinational helpers
   logic signed [XW-1:0]        t_x, d1_x, d2_x, f_x, e_x, s_x;
   logic signed [W-1:0]         e_new, t_clip;
   logic [1:0]                  hidx;
   logic signed [W-1:0]         tval;
   logic signed [WGT_WIDTH-1:0] tk;
   logic signed [SW-1:0]        term;
   logic                        out_free;

   msd_ser_mul #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_res),
      .stat    (mul_stat)
   );

   msd_ser_div #(.NUM_WIDTH(SW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .quotient (div_q),
      .stat     (div_stat)
   );

   always_comb begin
      t_x    = XW'(t0_ff) + XW'(elapsed_ff);
      t_clip = clip_x(t_x);
      d1_x   = XW'(pos_ff[0]) - XW'(xg_ff) - XW'(flen_ff);
      d2_x   = XW'(vel_ff[0]) - XW'(vg_ff);
      f_x    = XW'(facc_ff) + XW'(mul_res) + XW'(grav_ff);
      e_x    = XW'(elapsed_ff) + XW'($signed({1'b0, dt_ff}));
      e_new  = clip_x(e_x);
      s_x    = XW'(t0_ff) + XW'(e_new);
      hidx   = 2'(cnt_ff - 3'd1);
      if (cnt_ff == 3'd0) tval = h_ff;
      else if (state_ff == S_SUMV) tval = vel_ff[hidx];
      else tval = pos_ff[hidx];
      tk       = term_weight(ord_ff, cnt_ff);
      term     = SW'(tval) * SW'(tk);
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   // operand steering for the shared units
   always_comb begin
      case (state_ff)
         S_GMUL: begin
            mul_a = height_ff;
            mul_b = t_ff;
         end
         S_FK: begin
            mul_a = $signed({1'b0, stiff_ff});
            mul_b = clip_x(d1_x);
         end
         S_FD: begin
            mul_a = $signed({1'b0, damp_ff});
            mul_b = clip_x(d2_x);
         end
         S_ACC: begin
            mul_a = force_ff;
            mul_b = $signed({1'b0, invm_ff});
         end
         S_HV: begin
            mul_a = $signed({1'b0, dt_ff});
            mul_b = acc_ff;
         end
         default: begin
            mul_a = $signed({1'b0, dt_ff});
            mul_b = vnew_ff;
         end
      endcase
      case (state_ff)
         S_XGDIV: begin
            div_num = SW'(ramp_ff ? tmp_ff : height_ff);
            div_den = ramp_ff ? DIV_RAMP : DIV_HOLD;
         end
         S_VGDIV: begin
            div_num = SW'(height_ff);
            div_den = DIV_RAMP;
         end
         default: begin
            div_num = sum_ff;
            div_den = order_divisor(ord_ff);
         end
      endcase
   end

   always_comb begin
      stiff_in  = stiff_ff;
      damp_in   = damp_ff;
      invm_in   = invm_ff;
      grav_in   = grav_ff;
      flen_in   = flen_ff;
      dt_in     = dt_ff;
      height_in = height_ff;
      t0_in     = t0_ff;
      for (int i = 0; i < 4; i++) begin
         pos_in[i] = pos_ff[i];
         vel_in[i] = vel_ff[i];
      end
      steps_in     = steps_ff;
      elapsed_in   = elapsed_ff;
      state_in     = state_ff;
      run_in       = run_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ord_in       = ord_ff;
      ramp_in      = ramp_ff;
      sat_in       = sat_ff;
      t_in         = t_ff;
      tmp_in       = tmp_ff;
      xg_in        = xg_ff;
      vg_in        = vg_ff;
      facc_in      = facc_ff;
      force_in     = force_ff;
      acc_in       = acc_ff;
      h_in         = h_ff;
      sum_in       = sum_ff;
      vnew_in      = vnew_ff;
      xnew_in      = xnew_ff;
      o_pos_in     = o_pos_ff;
      o_vel_in     = o_vel_ff;
      o_acc_in     = o_acc_ff;
      o_force_in   = o_force_ff;
      o_time_in    = o_time_ff;
      o_ord_in     = o_ord_ff;
      o_sat_in     = o_sat_ff;
      mul_start    = 1'b0;
      div_start    = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_STIFFNESS:    stiff_in  = csr_data[W-2:0];
            CSR_DAMPING:      damp_in   = csr_data[W-2:0];
            CSR_INVERSE_MASS: invm_in   = csr_data[W-2:0];
            CSR_GRAVITY:      grav_in   = csr_data;
            CSR_FREE_LENGTH:  flen_in   = csr_data;
            CSR_TIME_STEP:    dt_in     = csr_data[W-2:0];
            CSR_STEP_HEIGHT:  height_in = csr_data;
            CSR_START_TIME:   t0_in     = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_restart) begin
                  for (int i = 0; i < 4; i++) begin
                     pos_in[i] = HALF_W;
                     vel_in[i] = '0;
                  end
                  steps_in   = '0;
                  elapsed_in = '0;
                  ord_in     = '0;
               end else begin
                  ord_in = steps_ff;
               end
               sat_in   = 1'b0;
               state_in = S_TIME;
            end
         end
         S_TIME: begin
            t_in    = t_clip;
            sat_in  = sat_ff | ovf_x(t_x);
            ramp_in = t_clip < THR_W;
            state_in = (t_clip < THR_W) ? S_GMUL : S_XGDIV;
         end
         S_GMUL: begin
            if (!run_ff) begin
               mul_start = 1'b1;
               run_in    = 1'b1;
            end else if (mul_stat.done) begin
               run_in   = 1'b0;
               tmp_in   = mul_res;
               sat_in   = sat_ff | mul_stat.sat;
               state_in = S_XGDIV;
            end
         end
         S_XGDIV: begin
            if (!run_ff) begin
               div_start = 1'b1;
               run_in    = 1'b1;
            end else if (div_stat.done) begin
               run_in = 1'b0;
               xg_in  = div_q[W-1:0];
               sat_in = sat_ff | div_stat.sat;
               if (ramp_ff) begin
                  state_in = S_VGDIV;
               end else begin
                  vg_in    = '0;
                  state_in = S_FK;
               end
            end
         end
         S_VGDIV: begin
            if (!run_ff) begin
               div_start = 1'b1;
               run_in    = 1'b1;
            end else if (div_stat.done) begin
               run_in   = 1'b0;
               vg_in    = div_q[W-1:0];
               state_in = S_FK;
            end
         end
         S_FK: begin
            if (!run_ff) begin
               mul_start = 1'b1;
               run_in    = 1'b1;
               sat_in    = sat_ff | ovf_x(d1_x);
            end else if (mul_stat.done) begin
               run_in   = 1'b0;
               facc_in  = mul_res;
               sat_in   = sat_ff | mul_stat.sat;
               state_in = S_FD;
            end
         end
         S_FD: begin
            if (!run_ff) begin
               mul_start = 1'b1;
               run_in    = 1'b1;
               sat_in    = sat_ff | ovf_x(d2_x);
            end else if (mul_stat.done) begin
               run_in   = 1'b0;
               force_in = clip_x(f_x);
               sat_in   = sat_ff | mul_stat.sat | ovf_x(f_x);
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            if (!run_ff) begin
               mul_start = 1'b1;
               run_in    = 1'b1;
            end else if (mul_stat.done) begin
               run_in = 1'b0;
               // negation of the most negative value clips to the most positive
               acc_in = (mul_res == VMIN_W) ? VMAX_W : -mul_res;
               sat_in = sat_ff | mul_stat.sat | (mul_res == VMIN_W);
               state_in = S_HV;
            end
         end
         S_HV, S_HX: begin
            if (!run_ff) begin
               mul_start = 1'b1;
               run_in    = 1'b1;
            end else if (mul_stat.done) begin
               run_in   = 1'b0;
               h_in     = mul_res;
               sat_in   = sat_ff | mul_stat.sat;
               cnt_in   = '0;
               state_in = (state_ff == S_HV) ? S_SUMV : S_SUMX;
            end
         end
         S_SUMV, S_SUMX: begin
            sum_in = ((cnt_ff == 3'd0) ? SW'(0) : sum_ff) + term;
            if (cnt_ff == 3'd4) begin
               cnt_in   = '0;
               state_in = (state_ff == S_SUMV) ? S_DIVV : S_DIVX;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         S_DIVV, S_DIVX: begin
            if (!run_ff) begin
               div_start = 1'b1;
               run_in    = 1'b1;
            end else if (div_stat.done) begin
               run_in = 1'b0;
               sat_in = sat_ff | ovf_x(XW'(div_q));
               if (state_ff == S_DIVV) begin
                  vnew_in  = clip_x(XW'(div_q));
                  state_in = S_HX;
               end else begin
                  xnew_in  = clip_x(XW'(div_q));
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            // commit only once the output register is free
            if (out_free) begin
               for (int i = 3; i > 0; i--) begin
                  pos_in[i] = pos_ff[i-1];
                  vel_in[i] = vel_ff[i-1];
               end
               pos_in[0]  = xnew_ff;
               vel_in[0]  = vnew_ff;
               if (steps_ff != 2'd3) steps_in = steps_ff + 2'd1;
               elapsed_in = e_new;
               o_pos_in   = xnew_ff;
               o_vel_in   = vnew_ff;
               o_acc_in   = acc_ff;
               o_force_in = force_ff;
               o_time_in  = clip_x(s_x);
               o_ord_in   = {1'b0, ord_ff} + 3'd1;
               o_sat_in   = sat_ff | ovf_x(e_x) | ovf_x(s_x);
               rsp_valid_in = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stiff_ff  <= '0;
         damp_ff   <= '0;
         invm_ff   <= INVM_RST;
         grav_ff   <= '0;
         flen_ff   <= HALF_W;
         dt_ff     <= DT_RST;
         height_ff <= '0;
         t0_ff     <= '0;
         for (int i = 0; i < 4; i++) begin
            pos_ff[i] <= HALF_W;
            vel_ff[i] <= '0;
         end
         steps_ff     <= '0;
         elapsed_ff   <= '0;
         state_ff     <= S_IDLE;
         run_ff       <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stiff_ff  <= stiff_in;
         damp_ff   <= damp_in;
         invm_ff   <= invm_in;
         grav_ff   <= grav_in;
         flen_ff   <= flen_in;
         dt_ff     <= dt_in;
         height_ff <= height_in;
         t0_ff     <= t0_in;
         for (int i = 0; i < 4; i++) begin
            pos_ff[i] <= pos_in[i];
            vel_ff[i] <= vel_in[i];
         end
         steps_ff     <= steps_in;
         elapsed_ff   <= elapsed_in;
         state_ff     <= state_in;
         run_ff       <= run_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ord_ff     <= ord_in;
      ramp_ff    <= ramp_in;
      sat_ff     <= sat_in;
      t_ff       <= t_in;
      tmp_ff     <= tmp_in;
      xg_ff      <= xg_in;
      vg_ff      <= vg_in;
      facc_ff    <= facc_in;
      force_ff   <= force_in;
      acc_ff     <= acc_in;
      h_ff       <= h_in;
      sum_ff     <= sum_in;
      vnew_ff    <= vnew_in;
      xnew_ff    <= xnew_in;
      o_pos_ff   <= o_pos_in;
      o_vel_ff   <= o_vel_in;
      o_acc_ff   <= o_acc_in;
      o_force_ff <= o_force_in;
      o_time_ff  <= o_time_in;
      o_ord_ff   <= o_ord_in;
      o_sat_ff   <= o_sat_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_new_position = o_pos_ff;
   assign rsp_new_velocity = o_vel_ff;
   assign rsp_acceleration = o_acc_ff;
   assign rsp_net_force    = o_force_ff;
   assign rsp_sim_time     = o_time_ff;
   assign rsp_order_used   = o_ord_ff;
   assign rsp_saturated    = o_sat_ff;

endmodule

[hdl/msd_checker.sv]
// Port-level checker for the step core, bound to the top level
`timescale 1ns / 1ps
`include "mass_spring_damper_bdf_step_core_assert.svh"
module msd_checker #(
   parameter int DATA_WIDTH = msd_pkg::DATA_WIDTH_DEF
)(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic signed [DATA_WIDTH-1:0] rsp_new_position,
   input logic [2:0]                   rsp_order_used
);
   import msd_pkg::*;

   // a held result word keeps its value
   `MSD_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_new_position), "held result word changed")

   // a taken request occupies the sequencer
   `MSD_ASSERT_NXT(a_busy_after_req, req_valid && !req_stall, req_stall, "no busy after request word")

   // a new result is only posted as the sequencer returns to idle
   `MSD_ASSERT_IMP(a_idle_at_result, $rose(rsp_valid), !req_stall, "result posted while busy")

   // formula order stays within one to four
   `MSD_ASSERT_IMP(a_order_range, rsp_valid, (rsp_order_used != 3'd0) && (rsp_order_used <= 3'd4), "order out of range")

endmodule

bind mass_spring_damper_bdf_step_core msd_checker #(.DATA_WIDTH(DATA_WIDTH)) u_msd_checker (.*);

[verif/mass_spring_damper_bdf_step_core_tb.sv]
// Self-checking testbench for the mass-spring-damper BDF step core
`timescale 1ns / 1ps
module mass_spring_damper_bdf_step_core_tb;
   import msd_pkg::*;

   localparam int W = 48;
   localparam longint VMAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint VMIN = -VMAX - 1;
   localparam longint I64MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint I64MIN = -I64MAX - 1;
   localparam longint ONE_Q = 64'sd16777216;
   localparam longint HALF_Q = 64'sd8388608;
   localparam longint RAMP_END = 64'sd838861;   // 0.05 s in Q24.24
   localparam longint DT_RESET = 64'sd16777;
   localparam longint CYCLE_LIMIT = 64'd12_000_000;
   localparam int HOLD_CYCLES = 2500;
   localparam int N_ITEMS = 1650;

   // BDF tables: h weight, history weights (newest first), divisor
   localparam int H_WT[4] = '{1, 2, 6, 12};
   localparam int DIV_WT[4] = '{1, 3, 11, 25};
   localparam int HIST_WT[4][4] = '{'{1, 0, 0, 0}, '{4, -1, 0, 0},
                                     '{18, -9, 2, 0}, '{48, -36, 16, -3}};

   typedef struct packed {
      logic [W-1:0] pos;
      logic [W-1:0] vel;
      logic [W-1:0] acc;
      logic [W-1:0] force_q;
      logic [W-1:0] sim;
      logic [2:0]   ord;
      logic         sat;
   } step_word_type;

   typedef struct {
      bit            is_cfg;
      logic [2:0]    idx;
      logic [W-1:0]  data;
      bit            restart;
      bit            typed;
      step_word_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_restart = 1'b0;
   logic rsp_stall = 1'b0;
   logic csr_valid = 1'b0;
   logic [2:0] csr_index = '0;
   logic [W-1:0] csr_data = '0;
   wire req_stall, rsp_valid, csr_ready, rsp_saturated;
   wire signed [W-1:0] rsp_new_position, rsp_new_velocity, rsp_acceleration;
   wire signed [W-1:0] rsp_net_force, rsp_sim_time;
   wire [2:0] rsp_order_used;

   mass_spring_damper_bdf_step_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_restart(req_restart),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_new_position(rsp_new_position), .rsp_new_velocity(rsp_new_velocity),
      .rsp_acceleration(rsp_acceleration), .rsp_net_force(rsp_net_force),
      .rsp_sim_time(rsp_sim_time), .rsp_order_used(rsp_order_used),
      .rsp_saturated(rsp_saturated),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------
   // Predictor state: register copies and integrator history
   // ---------------------------------------------------------------
   longint stiff_r, damp_r, inv_mass_r, grav_r, free_len_r, dt_r, height_r, t0_r;
   longint pos_hist[4];
   longint vel_hist[4];
   int     steps_done;
   longint elapsed;
   bit     clipped;          // any clip during the step being predicted

   step_word_type expected_words[$];
   stim_row_type  dir_rows[$];
   int  mismatches = 0;
   bit  calm = 1'b0;         // no idling on either side while set
   bit  hold_req = 1'b0;     // receiver holds off for HOLD_CYCLES
   int  hold_count = 0;
   longint cycles = 0;

   // queue helpers: append at the tail
   function automatic void queue_word(step_word_type w);
      expected_words.insert(expected_words.size(), w);
   endfunction

   function automatic void add_row(stim_row_type r);
      dir_rows.insert(dir_rows.size(), r);
   endfunction

   function automatic longint lim48(longint v);
      if (v > VMAX) begin clipped = 1'b1; return VMAX; end
      if (v < VMIN) begin clipped = 1'b1; return VMIN; end
      return v;
   endfunction

   function automatic longint add_sat(longint a, longint b);
      longint r;
      r = a + b;
      if (a[63] == b[63] && r[63] != a[63]) begin
         clipped = 1'b1;
         r = a[63] ? I64MIN : I64MAX;
      end
      return r;
   endfunction

   function automatic longint neg_sat(longint v);
      if (v == I64MIN) begin clipped = 1'b1; return lim48(I64MAX); end
      return lim48(-v);
   endfunction

   function automatic longint kmul(longint a, int k);
      logic signed [127:0] aw, mw, p;
      longint r;
      aw = a;
      mw = (k < 0) ? -k : k;
      if (mw == 0) return 0;
      p = aw * mw;
      if (p > I64MAX) begin clipped = 1'b1; r = I64MAX; end
      else if (p < I64MIN) begin clipped = 1'b1; r = I64MIN; end
      else r = p[63:0];
      if (k < 0) begin
         if (r == I64MIN) begin clipped = 1'b1; return I64MAX; end
         return -r;
      end
      return r;
   endfunction

   // Q24.24 product, round half away from zero, clip to 48 bits
   function automatic longint mul_q(longint a, longint b);
      bit neg;
      logic [63:0] ma, mb, lim;
      logic [127:0] p;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      p = ({64'd0, ma} * {64'd0, mb} + 128'd8388608) >> 24;
      lim = neg ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
      if (p > {64'd0, lim}) begin clipped = 1'b1; p = {64'd0, lim}; end
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
   endfunction

   function automatic longint div_round(longint n, int d);
      logic [63:0] m, q;
      m = (n < 0) ? -n : n;
      q = (m + 64'(d / 2)) / 64'(d);
      return (n < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic void clear_history();
      for (int i = 0; i < 4; i++) begin
         pos_hist[i] = HALF_Q;
         vel_hist[i] = 0;
      end
      steps_done = 0;
      elapsed = 0;
   endfunction

   function automatic void store_register(logic [2:0] idx, logic [W-1:0] d);
      longint u, s;
      u = longint'({17'd0, d[W-2:0]});
      s = longint'({{16{d[W-1]}}, d});
      case (idx)
         CSR_STIFFNESS:    stiff_r = u;
         CSR_DAMPING:      damp_r = u;
         CSR_INVERSE_MASS: inv_mass_r = u;
         CSR_GRAVITY:      grav_r = s;
         CSR_FREE_LENGTH:  free_len_r = s;
         CSR_TIME_STEP:    dt_r = u;
         CSR_STEP_HEIGHT:  height_r = s;
         default:          t0_r = s;
      endcase
   endfunction

   // one integration step: ground, force, acceleration, BDF velocity and position
   function automatic step_word_type integrate_step(bit restart);
      step_word_type o;
      longint t, xg, vg, d, f, a, h, acc_sum, v_new, x_new, sim;
      int ord;
      clipped = 1'b0;
      if (restart) clear_history();
      ord = steps_done;
      t = lim48(add_sat(t0_r, elapsed));
      if (t < RAMP_END) begin
         xg = div_round(mul_q(height_r, t), 50);
         vg = div_round(height_r, 50);
      end else begin
         xg = div_round(height_r, 1000);
         vg = 0;
      end
      d = lim48(add_sat(add_sat(pos_hist[0], -xg), -free_len_r));
      f = mul_q(stiff_r, d);
      d = lim48(add_sat(vel_hist[0], -vg));
      f = add_sat(f, mul_q(damp_r, d));
      f = lim48(add_sat(f, grav_r));
      a = neg_sat(mul_q(f, inv_mass_r));

      h = mul_q(dt_r, a);
      acc_sum = kmul(h, H_WT[ord]);
      for (int i = 0; i < 4; i++)
         acc_sum = add_sat(acc_sum, kmul(vel_hist[i], HIST_WT[ord][i]));
      v_new = lim48(div_round(acc_sum, DIV_WT[ord]));

      h = mul_q(dt_r, v_new);
      acc_sum = kmul(h, H_WT[ord]);
      for (int i = 0; i < 4; i++)
         acc_sum = add_sat(acc_sum, kmul(pos_hist[i], HIST_WT[ord][i]));
      x_new = lim48(div_round(acc_sum, DIV_WT[ord]));

      for (int i = 3; i > 0; i--) begin
         pos_hist[i] = pos_hist[i-1];
         vel_hist[i] = vel_hist[i-1];
      end
      pos_hist[0] = x_new;
      vel_hist[0] = v_new;
      if (steps_done < 3) steps_done++;
      elapsed = lim48(add_sat(elapsed, dt_r));
      sim = lim48(add_sat(t0_r, elapsed));

      o.pos = x_new[W-1:0];
      o.vel = v_new[W-1:0];
      o.acc = a[W-1:0];
      o.force_q = f[W-1:0];
      o.sim = sim[W-1:0];
      o.ord = 3'(ord + 1);
      o.sat = clipped;
      return o;
   endfunction

   function automatic stim_row_type item_row(bit restart, bit typed, int n);
      stim_row_type r;
      r = '{default: '0};
      r.restart = restart;
      r.typed = typed;
      // quiescent system: stays at 0.5, time advances by dt
      r.want.pos = W'(HALF_Q);
      r.want.sim = W'(DT_RESET * n);
      r.want.ord = (n > 4) ? 3'd4 : 3'(n);
      return r;
   endfunction

   function automatic stim_row_type cfg_row(logic [2:0] idx, logic [W-1:0] d);
      stim_row_type r;
      r = '{default: '0};
      r.is_cfg = 1'b1;
      r.idx = idx;
      r.data = d;
      return r;
   endfunction

   // register values: extremes, full random, or moderate magnitudes
   function automatic logic [W-1:0] pick_value(logic [2:0] idx);
      longint m;
      case ($urandom_range(0, 9))
         0: return '0;
         1: return {W{1'b1}};
         2: return {1'b1, {(W-1){1'b0}}};
         3: return W'({$urandom, $urandom});
         4: return {1'b0, {(W-1){1'b1}}};
         default: begin
            m = longint'($urandom) & ((64'sd1 <<< $urandom_range(8, 30)) - 1);
            if (idx == CSR_INVERSE_MASS) m = m + ONE_Q / 4;
            if (idx == CSR_TIME_STEP) m = m >>> 4;
            if (idx == CSR_START_TIME && $urandom_range(0, 1)) m = RAMP_END - (m >>> 12);
            if ($urandom_range(0, 1) && (idx == CSR_GRAVITY || idx == CSR_FREE_LENGTH
                  || idx == CSR_STEP_HEIGHT || idx == CSR_START_TIME))
               m = -m;
            return W'(m);
         end
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Drivers: inputs change only at the falling edge
   // ---------------------------------------------------------------
   task automatic drain();
      while (expected_words.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_register(logic [2:0] idx, logic [W-1:0] d);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = d;
      do @(posedge clock); while (!csr_ready);
      store_register(idx, d);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // offer one request word; prediction is made at the edge that accepts it
   task automatic send_step(bit restart, bit typed, step_word_type want);
      step_word_type p;
      while (!calm && $urandom_range(0, 99) < 29) begin
         req_valid = 1'b0;
         req_restart = $urandom_range(0, 1);
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_restart = restart;
      do @(posedge clock); while (req_stall);
      p = integrate_step(restart);
      queue_word(typed ? want : p);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // receiver: random stalls, or a long hold-off so the block backs up
   always @(negedge clock) begin
      if (hold_req) begin
         rsp_stall = 1'b1;
         hold_count++;
         if (hold_count >= HOLD_CYCLES) begin
            hold_req = 1'b0;
            hold_count = 0;
         end
      end else begin
         rsp_stall = !calm && ($urandom_range(0, 99) < 29);
      end
   end

   task automatic report(string fld, logic [W-1:0] want, logic [W-1:0] got);
      $display("%0t mismatch %s expected %h actual %h", $time, fld, want, got);
   endtask

   // checker: compare each accepted result word with the oldest prediction
   always @(posedge clock) begin
      step_word_type w;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $display("%0t unexpected result word, position %h", $time, rsp_new_position);
            mismatches++;
         end else begin
            w = expected_words.pop_front();
            if (w.pos !== rsp_new_position) begin
               report("new_position", w.pos, rsp_new_position); mismatches++;
            end
            if (w.vel !== rsp_new_velocity) begin
               report("new_velocity", w.vel, rsp_new_velocity); mismatches++;
            end
            if (w.acc !== rsp_acceleration) begin
               report("acceleration", w.acc, rsp_acceleration); mismatches++;
            end
            if (w.force_q !== rsp_net_force) begin
               report("net_force", w.force_q, rsp_net_force); mismatches++;
            end
            if (w.sim !== rsp_sim_time) begin
               report("sim_time", w.sim, rsp_sim_time); mismatches++;
            end
            if (w.ord !== rsp_order_used) begin
               report("order_used", W'(w.ord), W'(rsp_order_used)); mismatches++;
            end
            if (w.sat !== rsp_saturated) begin
               report("saturated", W'(w.sat), W'(rsp_saturated)); mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      stim_row_type r;
      step_word_type none;
      int sent, n, phase;
      none = '0;
      stiff_r = 0; damp_r = 0; inv_mass_r = ONE_Q; grav_r = 0;
      free_len_r = HALF_Q; dt_r = DT_RESET; height_r = 0; t0_r = 0;
      clear_history();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: quiescent steps through every order, restart, then extremes
      for (int k = 1; k <= 5; k++) add_row(item_row(1'b0, 1'b1, k));
      add_row(item_row(1'b1, 1'b1, 1));
      add_row(cfg_row(CSR_STIFFNESS, {W{1'b1}}));
      add_row(cfg_row(CSR_GRAVITY, {1'b1, {(W-1){1'b0}}}));
      add_row(item_row(1'b0, 1'b0, 0));
      add_row(item_row(1'b0, 1'b0, 0));
      add_row(cfg_row(CSR_INVERSE_MASS, {W{1'b1}}));
      add_row(cfg_row(CSR_TIME_STEP, {W{1'b1}}));
      add_row(item_row(1'b0, 1'b0, 0));
      add_row(item_row(1'b0, 1'b0, 0));
      add_row(cfg_row(CSR_STIFFNESS, '0));
      add_row(cfg_row(CSR_GRAVITY, '0));
      add_row(cfg_row(CSR_TIME_STEP, W'(DT_RESET * 4)));
      // ground ramp: 5000 mm step, time stays inside the 0.05 s ramp during the run
      add_row(cfg_row(CSR_STEP_HEIGHT, W'(64'sd5000 * ONE_Q)));
      add_row(cfg_row(CSR_DAMPING, W'(ONE_Q * 3)));
      add_row(item_row(1'b1, 1'b0, 0));
      add_row(item_row(1'b0, 1'b0, 0));
      add_row(cfg_row(CSR_START_TIME, {1'b0, {(W-1){1'b1}}}));
      add_row(cfg_row(CSR_FREE_LENGTH, {1'b1, {(W-1){1'b0}}}));
      add_row(item_row(1'b1, 1'b0, 0));
      add_row(item_row(1'b0, 1'b0, 0));

      foreach (dir_rows[i]) begin
         r = dir_rows[i];
         if (r.is_cfg) begin
            drain();
            write_register(r.idx, r.data);
         end else begin
            send_step(r.restart, r.typed, r.want);
         end
      end

      // random phases: new settings, then a run of steps with rare restarts
      sent = 0;
      phase = 0;
      while (sent < N_ITEMS) begin
         drain();
         calm = 1'b0;
         for (int i = 0; i < 8; i++)
            if (phase == 0 || $urandom_range(0, 2) == 0)
               write_register(3'(i), pick_value(3'(i)));
         calm = (phase == 2);
         if (phase == 4) hold_req = 1'b1;
         n = $urandom_range(20, 90);
         for (int k = 0; k < n; k++) begin
            // sender pause mid-run until every word is back
            if (phase == 6 && k == n / 2)
               while (expected_words.size() != 0) @(negedge clock);
            send_step($urandom_range(0, 99) < 4, 1'b0, none);
         end
         sent += n;
         phase++;
      end

      calm = 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (600) @(negedge clock);
      if (mismatches == 0 && expected_words.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

[filelist.f]
+incdir+hdl
hdl/msd_pkg.sv
hdl/msd_ser_mul.sv
hdl/msd_ser_div.sv
hdl/mass_spring_damper_bdf_step_core.sv
hdl/msd_checker.sv
verif/mass_spring_damper_bdf_step_core_tb.sv
